FILE: sv/p2r_pkg.sv
`default_nettype none

package p2r_pkg;

    // input word kinds
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    // source format register codes; the unused code behaves as 32 bpp
    localparam logic [1:0] FMT_INDEXED8 = 2'd0;
    localparam logic [1:0] FMT_RGB565   = 2'd1;
    localparam logic [1:0] FMT_ARGB32   = 2'd2;

    localparam logic [1:0] FORMAT_RESET = FMT_ARGB32;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_PIXEL_DIRECT  = 2'd0,
        OP_PIXEL_INDEXED = 2'd1,
        OP_PALETTE_WRITE = 2'd2
    } op_t;

    // one classified word between front and back
    typedef struct packed {
        op_t         op;
        logic [7:0]  idx;
        logic [31:0] data;   // palette value, or RGB888 in the low 24 bits
    } cmd_t;

    function automatic logic [23:0] expand_565(input logic [15:0] v);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = v[15:11];
        g6 = v[10:5];
        b5 = v[4:0];
        return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
    endfunction

endpackage

`default_nettype wire

FILE: sv/p2r_front.sv
`default_nettype none

module p2r_front (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        s_kind,
    input  wire logic [31:0] s_pixel_word,
    input  wire logic [7:0]  s_entry_index,
    input  wire logic [31:0] s_entry_value,
    output p2r_pkg::cmd_t    cmd
);

    logic [1:0] source_format_reg;
    logic [1:0] source_format_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        source_format_next = source_format_reg;
        if (cfg_valid) begin
            source_format_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_format_reg <= p2r_pkg::FORMAT_RESET;
        end else begin
            source_format_reg <= source_format_next;
        end
    end

    // direct formats are fully converted here; only indexed pixels need the palette
    always_comb begin
        cmd.op   = p2r_pkg::OP_PIXEL_DIRECT;
        cmd.idx  = s_pixel_word[7:0];
        cmd.data = {8'h00, s_pixel_word[23:0]};
        if (s_kind == p2r_pkg::KIND_PALETTE) begin
            cmd.op   = p2r_pkg::OP_PALETTE_WRITE;
            cmd.idx  = s_entry_index;
            cmd.data = s_entry_value;
        end else begin
            case (source_format_reg)
                p2r_pkg::FMT_INDEXED8: begin
                    cmd.op = p2r_pkg::OP_PIXEL_INDEXED;
                end
                p2r_pkg::FMT_RGB565: begin
                    cmd.data = {8'h00, p2r_pkg::expand_565(s_pixel_word[15:0])};
                end
                default: begin
                    cmd.data = {8'h00, s_pixel_word[23:0]};
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/p2r_queue.sv
`default_nettype none

module p2r_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire p2r_pkg::cmd_t push_cmd,
    output logic               pop_valid,
    input  wire logic          pop,
    output p2r_pkg::cmd_t      pop_cmd
);

    localparam int CW = $clog2(p2r_pkg::QUEUE_DEPTH + 1);
    localparam int PW = $clog2(p2r_pkg::QUEUE_DEPTH);

    p2r_pkg::cmd_t slot_reg [p2r_pkg::QUEUE_DEPTH];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(p2r_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/p2r_back.sv
`default_nettype none

module p2r_back #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire p2r_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_red,
    output logic [7:0]         m_green,
    output logic [7:0]         m_blue
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // RGB only; alpha matters just for the nonzero flags
    logic [23:0] palette_mem [TABLE_ENTRIES];
    logic [23:0] rd_data_reg;

    logic [TABLE_ENTRIES-1:0] nz_reg;
    logic [TABLE_ENTRIES-1:0] nz_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    p2r_pkg::op_t  out_op_reg;
    logic [7:0]    out_idx_reg;
    logic [23:0]   out_direct_reg;
    logic          out_gray_reg;
    logic          out_hit_reg;

    logic          out_free;
    logic          is_write_op;
    logic          in_range;
    logic [AW-1:0] addr;
    logic          wr_en;
    logic          pix_en;
    logic          was_set;
    logic          now_set;

    assign is_write_op = (q_cmd.op == p2r_pkg::OP_PALETTE_WRITE);
    assign out_free    = !out_valid_reg || m_ready;
    assign q_pop       = q_valid && (is_write_op || out_free);
    assign in_range    = ({1'b0, q_cmd.idx} < 9'(TABLE_ENTRIES));
    assign addr        = q_cmd.idx[AW-1:0];
    assign wr_en       = q_pop && is_write_op && in_range;
    assign pix_en      = q_pop && !is_write_op;
    assign was_set     = nz_reg[addr];
    assign now_set     = (q_cmd.data != '0);

    always_comb begin
        nz_next    = nz_reg;
        count_next = count_reg;
        if (wr_en) begin
            nz_next[addr] = now_set;
            if (was_set && !now_set) begin
                count_next = count_reg - 1'b1;
            end else if (!was_set && now_set) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pix_en) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nz_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            nz_reg        <= nz_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            palette_mem[addr] <= q_cmd.data[23:0];
        end
        if (pix_en) begin
            rd_data_reg <= palette_mem[addr];
        end
    end

    // palette state is sampled when the pixel leaves the queue
    always_ff @(posedge aclk) begin
        if (pix_en) begin
            out_op_reg     <= q_cmd.op;
            out_idx_reg    <= q_cmd.idx;
            out_direct_reg <= q_cmd.data[23:0];
            out_gray_reg   <= (count_reg == '0);
            out_hit_reg    <= in_range && was_set;
        end
    end

    always_comb begin
        m_red   = out_direct_reg[23:16];
        m_green = out_direct_reg[15:8];
        m_blue  = out_direct_reg[7:0];
        case (out_op_reg)
            p2r_pkg::OP_PIXEL_INDEXED: begin
                if (out_gray_reg) begin
                    m_red   = out_idx_reg;
                    m_green = out_idx_reg;
                    m_blue  = out_idx_reg;
                end else if (out_hit_reg) begin
                    m_red   = rd_data_reg[23:16];
                    m_green = rd_data_reg[15:8];
                    m_blue  = rd_data_reg[7:0];
                end else begin
                    m_red   = 8'h00;
                    m_green = 8'h00;
                    m_blue  = 8'h00;
                end
            end
            default: begin
                m_red   = out_direct_reg[23:16];
                m_green = out_direct_reg[15:8];
                m_blue  = out_direct_reg[7:0];
            end
        endcase
    end

    assign m_valid = out_valid_reg;

    a_count_matches_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CW'($countones(nz_reg)))
        else $error("nonzero count out of step with entry flags");

    a_pixel_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_en |-> out_free)
        else $error("pixel issued while result register is held");

    a_write_leaves_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && is_write_op && out_valid_reg && !m_ready) |=> out_valid_reg)
        else $error("palette write dropped a pending result");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !wr_en |=> count_reg == $past(count_reg))
        else $error("nonzero count moved without a palette write");

endmodule

`default_nettype wire

FILE: sv/pixel_to_rgb888_converter.sv
// Pixel to RGB888 converter.
// s_ channel: one word per pixel (s_kind = 0) or per palette write (s_kind = 1).
// Pixels are read per the source format register: 8 bpp index into a palette,
// 16 bpp RGB565 with high bits replicated, or 32 bpp ARGB with alpha dropped.
// An 8 bpp pixel comes out as gray (index on all channels) while every palette
// entry is zero. Palette writes produce no m_ word.
// cfg channel: writes the 2-bit source format; change it only when idle.
// m_ channel: red, green, blue per pixel, in input order.
// Throughput: one word per clock while the queue is not full. The queue slot
// is written at the s_ accept edge; the output register, m_valid and the
// palette read load when the pixel leaves the queue, which waits while a
// result is held. The 2-entry queue lets the input keep taking words while m_
// stalls; s_ready drops once the queue is full. Palette writes drain from the
// queue even while a result is held.
// Reset (aresetn low, synchronous): queue and output empty, palette reads as
// all zero, source format is 32 bpp. No clearing pass; per-entry flags are
// cleared at once.
`default_nettype none

module pixel_to_rgb888_converter #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [31:0] s_pixel_word,
    input  wire logic [7:0]  s_entry_index,
    input  wire logic [31:0] s_entry_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue
);

    p2r_pkg::cmd_t front_cmd;
    p2r_pkg::cmd_t q_cmd;
    logic          q_valid;
    logic          q_pop;

    p2r_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_kind        (s_kind),
        .s_pixel_word  (s_pixel_word),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .cmd           (front_cmd)
    );

    p2r_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    p2r_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_red    (m_red),
        .m_green  (m_green),
        .m_blue   (m_blue)
    );

endmodule

`default_nettype wire

FILE: dv/pixel_to_rgb888_converter_checker.sv
`timescale 1ns / 1ps

module pixel_to_rgb888_converter_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_kind,
    input  logic [31:0] s_pixel_word,
    input  logic [7:0]  s_entry_index,
    input  logic [31:0] s_entry_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_red,
    input  logic [7:0]  m_green,
    input  logic [7:0]  m_blue,
    output int          mismatches,
    output int          outstanding,
    output int          results_seen
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic [31:0] palette [256];
    logic [8:0]  live_entries;
    logic [1:0]  fmt;
    rgb_t        rgb_due [$];
    int          i;

    function automatic rgb_t convert_pixel(input logic [31:0] w);
        rgb_t        c;
        logic [31:0] argb;
        logic [4:0]  r5;
        logic [5:0]  g6;
        logic [4:0]  b5;
        case (fmt)
            p2r_pkg::FMT_INDEXED8: begin
                // empty palette: index shows as gray
                if (live_entries == 9'd0) begin
                    c = {w[7:0], w[7:0], w[7:0]};
                end else begin
                    argb = palette[w[7:0]];
                    c = {argb[23:16], argb[15:8], argb[7:0]};
                end
            end
            p2r_pkg::FMT_RGB565: begin
                r5 = w[15:11];
                g6 = w[10:5];
                b5 = w[4:0];
                c.red   = (8'(r5) << 3) | (8'(r5) >> 2);
                c.green = (8'(g6) << 2) | (8'(g6) >> 4);
                c.blue  = (8'(b5) << 3) | (8'(b5) >> 2);
            end
            default: begin
                c = {w[23:16], w[15:8], w[7:0]};
            end
        endcase
        return c;
    endfunction

    task automatic store_entry(input logic [7:0] idx, input logic [31:0] val);
        if (palette[idx] != 32'd0 && val == 32'd0) begin
            live_entries = live_entries - 9'd1;
        end else if (palette[idx] == 32'd0 && val != 32'd0) begin
            live_entries = live_entries + 9'd1;
        end
        palette[idx] = val;
    endtask

    task automatic report_mismatch(input string msg);
        mismatches = mismatches + 1;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        rgb_t want;
        if (!aresetn) begin
            for (i = 0; i < 256; i++) begin
                palette[i] = 32'd0;
            end
            live_entries = 9'd0;
            fmt = p2r_pkg::FORMAT_RESET;
            rgb_due.delete();
            mismatches = 0;
            results_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                fmt = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (rgb_due.size() == 0) begin
                    report_mismatch($sformatf("word %02h %02h %02h with nothing expected",
                                              m_red, m_green, m_blue));
                end else begin
                    want = rgb_due.pop_front();
                    if (m_red !== want.red) begin
                        report_mismatch($sformatf("red got %02h want %02h",
                                                  m_red, want.red));
                    end
                    if (m_green !== want.green) begin
                        report_mismatch($sformatf("green got %02h want %02h",
                                                  m_green, want.green));
                    end
                    if (m_blue !== want.blue) begin
                        report_mismatch($sformatf("blue got %02h want %02h",
                                                  m_blue, want.blue));
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (s_valid && s_ready) begin
                if (s_kind == p2r_pkg::KIND_PALETTE) begin
                    store_entry(s_entry_index, s_entry_value);
                end else begin
                    rgb_due = {rgb_due, convert_pixel(s_pixel_word)};
                end
            end
        end
        outstanding <= rgb_due.size();
    end

endmodule

FILE: dv/pixel_to_rgb888_converter_tb.sv
`timescale 1ns / 1ps

module pixel_to_rgb888_converter_tb;

    localparam logic [1:0] FMT_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_PHASES  = 8;
    localparam int         PHASE_WORDS    = 100;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [31:0] s_pixel_word;
    logic [7:0]  s_entry_index;
    logic [31:0] s_entry_value;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;

    int mismatches;
    int outstanding;
    int results_seen;
    int s_gap_max      = 9;
    int m_gap_max      = 9;
    int pixels_sent    = 0;
    int palette_writes = 0;
    int format_writes  = 0;
    int idle_cycles    = 0;

    pixel_to_rgb888_converter dut (
        .aclk, .aresetn,
        .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_kind, .s_pixel_word, .s_entry_index, .s_entry_value,
        .m_valid, .m_ready, .m_red, .m_green, .m_blue
    );

    pixel_to_rgb888_converter_checker checker_i (
        .aclk, .aresetn,
        .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_kind, .s_pixel_word, .s_entry_index, .s_entry_value,
        .m_valid, .m_ready, .m_red, .m_green, .m_blue,
        .mismatches, .outstanding, .results_seen
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // valid stays up across back-to-back words; only dropped for a gap
    task automatic send_word(input logic kind, input logic [31:0] pix,
                             input logic [7:0] idx, input logic [31:0] val);
        int gap;
        gap = $urandom_range(0, s_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_pixel_word  <= pix;
        s_entry_index <= idx;
        s_entry_value <= val;
        do @(posedge aclk); while (!s_ready);
        if (kind == p2r_pkg::KIND_PALETTE) palette_writes++;
        else pixels_sent++;
    endtask

    task automatic send_pixel(input logic [31:0] w);
        send_word(p2r_pkg::KIND_PIXEL, w, 8'($urandom), $urandom);
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [31:0] val);
        send_word(p2r_pkg::KIND_PALETTE, $urandom, idx, val);
    endtask

    // palette writes leave nothing to wait for, so allow the pipe to empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_format(input logic [1:0] f);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= f;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        format_writes++;
    endtask

    initial begin
        int gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = $urandom_range(0, m_gap_max);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        logic [1:0]  fmt;
        logic [7:0]  idx;
        logic [31:0] val;
        int          roll;
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= p2r_pkg::FMT_ARGB32;
        s_valid       <= 1'b0;
        s_kind        <= p2r_pkg::KIND_PIXEL;
        s_pixel_word  <= 32'd0;
        s_entry_index <= 8'd0;
        s_entry_value <= 32'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // 32 bpp straight after reset
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h1234_5678);

        set_format(p2r_pkg::FMT_INDEXED8);
        // gray while the palette is empty, upper bits ignored
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FF80);
        send_pixel(32'h0000_00FF);
        // alpha-only entry counts as set but shows black
        send_palette(8'd5, 32'hFF00_0000);
        send_pixel(32'h0000_0005);
        send_pixel(32'h0000_0006);
        // clear it again: back to gray
        send_palette(8'd5, 32'h0000_0000);
        send_pixel(32'h0000_0017);
        send_palette(8'd0, 32'hAABB_CCDD);
        send_palette(8'hFF, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FF00);
        send_pixel(32'h0000_00FF);

        set_format(p2r_pkg::FMT_RGB565);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_F800);
        send_pixel(32'h0000_07E0);
        send_pixel(32'h0000_001F);
        send_pixel(32'hFFFF_0000);

        set_format(FMT_UNUSED);
        send_pixel(32'h89AB_CDEF);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0, 4:    fmt = p2r_pkg::FMT_INDEXED8;
                1:       fmt = p2r_pkg::FMT_RGB565;
                2:       fmt = p2r_pkg::FMT_ARGB32;
                3:       fmt = FMT_UNUSED;
                default: fmt = 2'($urandom_range(0, 3));
            endcase
            set_format(fmt);
            s_gap_max = (p % 3 == 1) ? 0 : 9;
            m_gap_max = (p % 4 == 2) ? 0 : 9;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < ((fmt == p2r_pkg::FMT_INDEXED8) ? 30 : 10)) begin
                    // first indexed phase works a few entries so the palette
                    // keeps falling back to empty
                    if (p == 0) begin
                        idx = 8'($urandom_range(0, 4));
                        if (idx == 8'd4) idx = 8'hFF;
                    end else begin
                        idx = 8'($urandom);
                    end
                    roll = $urandom_range(0, 7);
                    if (roll < 3) val = 32'd0;
                    else if (roll == 3) val = 32'hFFFF_FFFF;
                    else val = $urandom;
                    send_palette(idx, val);
                end else begin
                    send_pixel($urandom);
                end
            end
        end
        s_gap_max = 9;
        m_gap_max = 9;
        settle();

        $display("Sent %0d pixel words and %0d palette writes over %0d format writes",
                 pixels_sent, palette_writes, format_writes);
        $display("Checked %0d converted words, all four format codes used", results_seen);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
sv/p2r_pkg.sv
sv/p2r_front.sv
sv/p2r_queue.sv
sv/p2r_back.sv
sv/pixel_to_rgb888_converter.sv
dv/pixel_to_rgb888_converter_checker.sv
dv/pixel_to_rgb888_converter_tb.sv
